@@ sv/fixed_point_q24_8_alu_macros.svh @@
// assertion macros
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH
`ifndef SYNTH
`define FPA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FPA_ASSERT_IMP(label, clk, rst, ante, cons)
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/fpa_pkg.sv @@
package fpa_pkg;
   localparam int FracBitsDefault = 8;
   localparam int DataWidth = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_EQ = 4'd4, OP_NE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
      OP_LE = 4'd8, OP_LT = 4'd9, OP_MAX = 4'd10, OP_MIN = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
   } opcode_type;

   typedef struct packed {
      logic             valid;
      logic             is_div;
      logic             neg;
      logic             derr;
      logic             cmp;
      logic [DataWidth-1:0] res;
   } ctl_type;
endpackage

@@ sv/fpa_front.sv @@
module fpa_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [3:0]               opcode,
   input  logic [31:0]              operand_a,
   input  logic [31:0]              operand_b,
   output fpa_pkg::ctl_type         ctl,
   output logic [31+FRAC_BITS:0]    dividend,
   output logic [31:0]              divisor
);
   import fpa_pkg::*;

   localparam int DW = 32 + FRAC_BITS;

   ctl_type ctl_ff, ctl_in;
   logic [DW-1:0] dividend_ff;
   logic [31:0] divisor_ff;
   logic [31:0] mag_a, mag_b;
   logic [63:0] prod;
   logic lt_ab, lt_ba;
   opcode_type op;

   assign op = opcode_type'(opcode);
   assign mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
   assign mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
   assign lt_ab = $signed(operand_a) < $signed(operand_b);
   assign lt_ba = $signed(operand_b) < $signed(operand_a);
   assign prod = {32'd0, mag_a} * {32'd0, mag_b};

   always_comb begin
      ctl_in = '0;
      ctl_in.valid = in_valid;
      ctl_in.neg = operand_a[31] ^ operand_b[31];
      unique case (op)
         OP_ADD: ctl_in.res = operand_a + operand_b;
         OP_SUB: ctl_in.res = operand_a - operand_b;
         OP_MUL: begin
            ctl_in.res = prod[FRAC_BITS +: 32];
            ctl_in.res = ctl_in.neg ? 32'(-ctl_in.res) : ctl_in.res;
         end
         OP_DIV: begin
            ctl_in.is_div = (operand_b != 32'd0);
            ctl_in.derr = (operand_b == 32'd0);
         end
         OP_EQ: ctl_in.cmp = operand_a == operand_b;
         OP_NE: ctl_in.cmp = operand_a != operand_b;
         OP_GT: ctl_in.cmp = lt_ba;
         OP_GE: ctl_in.cmp = !lt_ab;
         OP_LE: ctl_in.cmp = !lt_ba;
         OP_LT: ctl_in.cmp = lt_ab;
         OP_MAX: ctl_in.res = lt_ab ? operand_b : operand_a;
         OP_MIN: ctl_in.res = lt_ba ? operand_b : operand_a;
         OP_INC: ctl_in.res = operand_a + 32'd1;
         OP_DEC: ctl_in.res = operand_a - 32'd1;
         OP_FROM_INT: ctl_in.res = operand_a << FRAC_BITS;
         OP_TO_INT: ctl_in.res = 32'($signed(operand_a) >>> FRAC_BITS);
         default: ctl_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.is_div <= ctl_in.is_div;
         ctl_ff.neg <= ctl_in.neg;
         ctl_ff.derr <= ctl_in.derr;
         ctl_ff.cmp <= ctl_in.cmp;
         ctl_ff.res <= ctl_in.res;
         dividend_ff <= {mag_a, FRAC_BITS'(0)};
         divisor_ff <= mag_b;
      end
   end

   assign ctl = ctl_ff;
   assign dividend = dividend_ff;
   assign divisor = divisor_ff;
endmodule

@@ sv/fpa_div_cell.sv @@
module fpa_div_cell #(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  fpa_pkg::ctl_type         ctl_i,
   input  logic [32:0]              rem_i,
   input  logic [31+FRAC_BITS:0]    num_i,
   input  logic [31:0]              den_i,
   output fpa_pkg::ctl_type         ctl_o,
   output logic [32:0]              rem_o,
   output logic [31+FRAC_BITS:0]    num_o,
   output logic [31:0]              den_o
);
   import fpa_pkg::*;

   localparam int DW = 32 + FRAC_BITS;

   ctl_type ctl_ff;
   logic [32:0] rem_ff, rem_in, trial;
   logic [DW-1:0] num_ff, num_in;
   logic [31:0] den_ff;
   logic take;

   always_comb begin
      trial = {rem_i[31:0], num_i[DW-1]};
      take = trial >= {1'b0, den_i};
      rem_in = take ? trial - {1'b0, den_i} : trial;
      num_in = {num_i[DW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (en) begin
         ctl_ff.is_div <= ctl_i.is_div;
         ctl_ff.neg <= ctl_i.neg;
         ctl_ff.derr <= ctl_i.derr;
         ctl_ff.cmp <= ctl_i.cmp;
         ctl_ff.res <= ctl_i.res;
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
endmodule

@@ sv/fixed_point_q24_8_alu.sv @@
// path: front register, then divide cell chain, then output register
// throughput: one word per cycle while the chain advances; one-bit restoring
// divide cells set the depth, every op rides the chain so results stay in order
// the chain advances whenever the output register is free or being taken
// reset: synchronous, clears all valid flags; no other state
`include "fixed_point_q24_8_alu_macros.svh"
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // opcode[3:0], operand_a[35:4], operand_b[67:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // result[31:0], compare_true[32], divide_error[33]
);
   import fpa_pkg::*;

   localparam int DW = 32 + FRAC_BITS;

   ctl_type ctl [DW+1];
   logic [32:0] rem [DW+1];
   logic [DW-1:0] num [DW+1];
   logic [31:0] den [DW+1];
   logic en;
   logic rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic [31:0] q, res_fin;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign rem[0] = '0;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid),
      .opcode(req_tdata[3:0]), .operand_a(req_tdata[35:4]),
      .operand_b(req_tdata[67:36]),
      .ctl(ctl[0]), .dividend(num[0]), .divisor(den[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_cell
      fpa_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .ctl_i(ctl[i]), .rem_i(rem[i]), .num_i(num[i]), .den_i(den[i]),
         .ctl_o(ctl[i+1]), .rem_o(rem[i+1]), .num_o(num[i+1]), .den_o(den[i+1])
      );
   end

   always_comb begin
      q = num[DW][31:0];
      res_fin = ctl[DW].res;
      if (ctl[DW].is_div) begin
         res_fin = ctl[DW].neg ? 32'(-q) : q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ctl[DW].valid;
      end
      if (en) begin
         rsp_data_ff <= {6'd0, ctl[DW].derr, ctl[DW].cmp, res_fin};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `FPA_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FPA_ASSERT_IMP(a_ready, clock, reset, !rsp_tvalid, req_tready)
   `FPA_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tdata[33],
      rsp_tdata[31:0] == 32'd0 && !rsp_tdata[32])
endmodule
